@@ sv/assert_macros.svh @@
// Assertion macros shared by the PNG encoder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with active-low asynchronous reset disable.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, fixed to the usual clock and reset names.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

@@ sv/pngenc_pkg.sv @@
// Package for the PNG stored-block RGBA encoder: types, codes, constants.
// No dependencies; used by pngenc_ctrl, pngenc_dp and the top level.
package pngenc_pkg;

	localparam int MAX_DIM_DEF   = 4096;
	localparam int BLOCK_MAX_DEF = 65535;
	localparam int CFG_W         = 13;
	localparam int CFG_IDX_W     = 1;
	localparam int IDX_W         = 6;

	localparam logic [31:0] CRC_POLY  = 32'hedb88320;
	localparam logic [16:0] ADLER_MOD = 17'd65521;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

	localparam logic [IDX_W-1:0] HDR_LAST      = 6'd42;
	localparam logic [IDX_W-1:0] HDR_IHDR_TYPE = 6'd12;
	localparam logic [IDX_W-1:0] HDR_IHDR_END  = 6'd28;
	localparam logic [IDX_W-1:0] HDR_IDAT_TYPE = 6'd37;
	localparam logic [IDX_W-1:0] BHDR_LAST     = 6'd4;
	localparam logic [IDX_W-1:0] TRL_ADLER_END = 6'd3;
	localparam logic [IDX_W-1:0] TRL_IEND_TYPE = 6'd12;
	localparam logic [IDX_W-1:0] TRL_IEND_END  = 6'd15;
	localparam logic [IDX_W-1:0] TRL_LAST      = 6'd19;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_DIVS, S_DIV, S_HDR, S_ROW, S_BCHK,
		S_BHDR, S_SCAN, S_CHK, S_TRL, S_WAIT
	} state_t;

	typedef enum logic [1:0] {
		SRC_HDR, SRC_BHDR, SRC_SCAN, SRC_TRL
	} src_t;

	typedef struct packed {
		logic             take;
		logic             cfg_ok;
		logic             mul;
		logic             div_start;
		logic             fire;
		src_t             src;
		logic [IDX_W-1:0] idx;
		logic             crc_en;
		logic             crc_init;
		logic             last;
		logic             scan;
		logic             filter;
		logic             blk_load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic div_busy;
		logic row_zero;
		logic blk_zero;
		logic stream_zero;
	} stat_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

	function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
		logic [7:0] r;
		unique case (k)
			2'd0: r = v[31:24];
			2'd1: r = v[23:16];
			2'd2: r = v[15:8];
			default: r = v[7:0];
		endcase
		return r;
	endfunction

endpackage

@@ sv/pngenc_ctrl.sv @@
// Sequencer for the PNG encoder: walks header, block header, scan and trailer beats.
// Depends on pngenc_pkg; drives pngenc_dp through cmd_t and reads stat_t.
module pngenc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  pngenc_pkg::stat_t  stat,
	output pngenc_pkg::cmd_t   cmd
);
	import pngenc_pkg::*;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             filt_q, filt_d;
	logic             emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			filt_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			filt_q  <= filt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		filt_d  = filt_q;
		unique case (state_q)
			S_IDLE: if (s_tvalid) state_d = S_MUL;
			S_WAIT: if (s_tvalid) state_d = S_ROW;
			S_MUL:  state_d = S_DIVS;
			S_DIVS: state_d = S_DIV;
			S_DIV: begin
				if (!stat.div_busy) begin
					state_d = S_HDR;
					idx_d   = '0;
				end
			end
			S_HDR: begin
				if (cmd.fire) begin
					if (idx_q == HDR_LAST) state_d = S_ROW;
					else idx_d = idx_q + 1'b1;
				end
			end
			S_ROW: begin
				filt_d  = stat.row_zero;
				state_d = S_BCHK;
			end
			S_BCHK: begin
				idx_d = '0;
				if (stat.blk_zero) state_d = S_BHDR;
				else state_d = S_SCAN;
			end
			S_BHDR: begin
				if (cmd.fire) begin
					if (idx_q == BHDR_LAST) state_d = S_SCAN;
					else idx_d = idx_q + 1'b1;
				end
			end
			S_SCAN: begin
				if (cmd.fire) begin
					if (filt_q) begin
						filt_d  = 1'b0;
						state_d = S_BCHK;
					end else begin
						state_d = S_CHK;
					end
				end
			end
			S_CHK: begin
				idx_d = '0;
				if (stat.stream_zero) state_d = S_TRL;
				else state_d = S_WAIT;
			end
			S_TRL: begin
				if (cmd.fire) begin
					if (idx_q == TRL_LAST) state_d = S_IDLE;
					else idx_d = idx_q + 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.src      = SRC_SCAN;
		cmd.idx      = idx_q;
		cmd.filter   = filt_q;
		s_tready     = 1'b0;
		emit         = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready   = 1'b1;
				cmd.cfg_ok = 1'b1;
			end
			S_WAIT: s_tready = 1'b1;
			S_MUL:  cmd.mul = 1'b1;
			S_DIVS: cmd.div_start = 1'b1;
			S_HDR: begin
				emit         = 1'b1;
				cmd.src      = SRC_HDR;
				cmd.crc_en   = (idx_q >= HDR_IHDR_TYPE && idx_q <= HDR_IHDR_END) ||
				               (idx_q >= HDR_IDAT_TYPE);
				cmd.crc_init = (idx_q == HDR_IHDR_TYPE) || (idx_q == HDR_IDAT_TYPE);
			end
			S_BHDR: begin
				emit         = 1'b1;
				cmd.src      = SRC_BHDR;
				cmd.crc_en   = 1'b1;
				cmd.blk_load = (idx_q == BHDR_LAST);
			end
			S_SCAN: begin
				emit       = 1'b1;
				cmd.src    = SRC_SCAN;
				cmd.crc_en = 1'b1;
				cmd.scan   = 1'b1;
			end
			S_TRL: begin
				emit         = 1'b1;
				cmd.src      = SRC_TRL;
				cmd.crc_en   = (idx_q <= TRL_ADLER_END) ||
				               (idx_q >= TRL_IEND_TYPE && idx_q <= TRL_IEND_END);
				cmd.crc_init = (idx_q == TRL_IEND_TYPE);
				cmd.last     = (idx_q == TRL_LAST);
			end
			default: ;
		endcase
		cmd.take = s_tvalid && s_tready;
		cmd.fire = emit && stat.out_free;
	end

endmodule

@@ sv/pngenc_dp.sv @@
// Datapath for the PNG encoder: size registers, length divider, CRC-32, Adler-32,
// stream counters and the output beat register. Depends on pngenc_pkg.
module pngenc_dp #(
	parameter int MAX_DIM   = pngenc_pkg::MAX_DIM_DEF,
	parameter int BLOCK_MAX = pngenc_pkg::BLOCK_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pngenc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pngenc_pkg::CFG_W-1:0]     cfg_data,
	input  logic [7:0]                       s_tdata,
	input  logic                             m_tready,
	input  pngenc_pkg::cmd_t                 cmd,
	output pngenc_pkg::stat_t                stat,
	output logic                             m_tvalid,
	output logic [7:0]                       m_tdata,
	output logic                             m_tuser
);
	import pngenc_pkg::*;

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int ROW_W  = $clog2(4 * MAX_DIM + 1);
	localparam int ST_W   = $clog2(MAX_DIM * (4 * MAX_DIM + 1) + 1);
	localparam int BLK_W  = $clog2(BLOCK_MAX + 1);
	localparam int NUM_W  = ST_W + 1;
	localparam int RCP_SH = NUM_W + $clog2(BLOCK_MAX);
	localparam int RCP_W  = NUM_W + 2;
	localparam int PROD_W = NUM_W + RCP_W;
	localparam logic [63:0] RCP =
		((64'd1 << RCP_SH) + 64'(BLOCK_MAX) - 64'd1) / 64'(BLOCK_MAX);
	localparam logic [RCP_W-1:0] RCP_M = RCP[RCP_W-1:0];

	logic [CFG_W-1:0]  width_q, height_q;
	logic [DIM_W-1:0]  wc, hc;
	logic [ST_W-1:0]   st_q;
	logic [NUM_W-1:0]  numer;
	logic [PROD_W-1:0] prod_q;
	logic              dbusy_q;
	logic [31:0]       idat_q, blocks;
	logic [31:0]       crc_q, crc_inv, crc_src;
	logic [15:0]       alo_q, ahi_q;
	logic [16:0]       alo_sum, ahi_sum;
	logic [15:0]       alo_n, ahi_n;
	logic [BLK_W-1:0]  blk_q, bsize;
	logic [15:0]       bsize16;
	logic              bfin;
	logic [ST_W-1:0]   stream_q;
	logic [ROW_W-1:0]  row_q, row_len;
	logic [7:0]        pix_q, scan_b, byte_d;

	always_comb begin
		if (width_q == '0) wc = DIM_W'(1);
		else if (32'(width_q) > MAX_DIM) wc = DIM_W'(MAX_DIM);
		else wc = DIM_W'(width_q);
		if (height_q == '0) hc = DIM_W'(1);
		else if (32'(height_q) > MAX_DIM) hc = DIM_W'(MAX_DIM);
		else hc = DIM_W'(height_q);
		row_len = ROW_W'(32'(wc) * 4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
		end else if (cfg_we && cmd.cfg_ok) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// block count = ceil(scan length / block size) by reciprocal multiply,
	// exact over the whole scan length range
	assign numer  = NUM_W'(st_q) + NUM_W'(BLOCK_MAX - 1);
	assign blocks = 32'(prod_q >> RCP_SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
		end else begin
			dbusy_q <= cmd.div_start;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) st_q <= ST_W'(32'(hc) * (32'(wc) * 4 + 1));
		if (cmd.div_start) prod_q <= PROD_W'(numer) * PROD_W'(RCP_M);
		if (dbusy_q) idat_q <= (blocks << 2) + blocks + 32'(st_q) + 32'd6;
	end

	assign scan_b  = cmd.filter ? 8'd0 : pix_q;
	assign alo_sum = {1'b0, alo_q} + {9'd0, scan_b};
	assign alo_n   = (alo_sum >= ADLER_MOD) ? 16'(alo_sum - ADLER_MOD) : alo_sum[15:0];
	assign ahi_sum = {1'b0, ahi_q} + {1'b0, alo_n};
	assign ahi_n   = (ahi_sum >= ADLER_MOD) ? 16'(ahi_sum - ADLER_MOD) : ahi_sum[15:0];

	assign bfin    = (32'(stream_q) <= BLOCK_MAX);
	assign bsize   = bfin ? BLK_W'(stream_q) : BLK_W'(BLOCK_MAX);
	assign bsize16 = 16'(bsize);
	assign crc_inv = ~crc_q;
	assign crc_src = cmd.crc_init ? 32'hffffffff : crc_q;

	always_ff @(posedge clk) begin
		if (cmd.take) pix_q <= s_tdata;
		if (cmd.mul) begin
			alo_q <= 16'd1;
			ahi_q <= 16'd0;
			blk_q <= '0;
			row_q <= '0;
		end
		if (cmd.div_start) stream_q <= st_q;
		if (cmd.fire && cmd.crc_en) crc_q <= crc_byte(crc_src, byte_d);
		if (cmd.fire && cmd.blk_load) blk_q <= bsize;
		if (cmd.fire && cmd.scan) begin
			alo_q <= alo_n;
			ahi_q <= ahi_n;
			if (blk_q != '0) blk_q <= blk_q - 1'b1;
			if (stream_q != '0) stream_q <= stream_q - 1'b1;
			if (cmd.filter) row_q <= row_len;
			else if (row_q != '0) row_q <= row_q - 1'b1;
		end
	end

	always_comb begin
		byte_d = 8'd0;
		unique case (cmd.src)
			SRC_HDR: begin
				unique case (cmd.idx)
					6'd0:  byte_d = 8'd137;
					6'd1:  byte_d = 8'd80;
					6'd2:  byte_d = 8'd78;
					6'd3:  byte_d = 8'd71;
					6'd4:  byte_d = 8'd13;
					6'd5:  byte_d = 8'd10;
					6'd6:  byte_d = 8'd26;
					6'd7:  byte_d = 8'd10;
					6'd11: byte_d = 8'd13;
					6'd12: byte_d = 8'h49;
					6'd13: byte_d = 8'h48;
					6'd14: byte_d = 8'h44;
					6'd15: byte_d = 8'h52;
					6'd16, 6'd17, 6'd18, 6'd19:
						byte_d = be_byte(32'(wc), cmd.idx[1:0]);
					6'd20, 6'd21, 6'd22, 6'd23:
						byte_d = be_byte(32'(hc), cmd.idx[1:0]);
					6'd24: byte_d = 8'd8;
					6'd25: byte_d = 8'd6;
					6'd29, 6'd30, 6'd31, 6'd32:
						byte_d = be_byte(crc_inv, 2'(cmd.idx - 6'd29));
					6'd33, 6'd34, 6'd35, 6'd36:
						byte_d = be_byte(idat_q, 2'(cmd.idx - 6'd33));
					6'd37: byte_d = 8'h49;
					6'd38: byte_d = 8'h44;
					6'd39: byte_d = 8'h41;
					6'd40: byte_d = 8'h54;
					6'd41: byte_d = 8'h78;
					6'd42: byte_d = 8'h01;
					default: byte_d = 8'd0;
				endcase
			end
			SRC_BHDR: begin
				unique case (cmd.idx)
					6'd0: byte_d = {7'd0, bfin};
					6'd1: byte_d = bsize16[7:0];
					6'd2: byte_d = bsize16[15:8];
					6'd3: byte_d = ~bsize16[7:0];
					default: byte_d = ~bsize16[15:8];
				endcase
			end
			SRC_SCAN: byte_d = scan_b;
			SRC_TRL: begin
				unique case (cmd.idx)
					6'd0, 6'd1, 6'd2, 6'd3:
						byte_d = be_byte({ahi_q, alo_q}, cmd.idx[1:0]);
					6'd4, 6'd5, 6'd6, 6'd7, 6'd16, 6'd17, 6'd18, 6'd19:
						byte_d = be_byte(crc_inv, cmd.idx[1:0]);
					6'd12: byte_d = 8'h49;
					6'd13: byte_d = 8'h45;
					6'd14: byte_d = 8'h4e;
					6'd15: byte_d = 8'h44;
					default: byte_d = 8'd0;
				endcase
			end
			default: byte_d = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.fire) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			m_tdata <= byte_d;
			m_tuser <= cmd.last;
		end
	end

	assign stat.out_free    = !m_tvalid || m_tready;
	assign stat.div_busy    = dbusy_q;
	assign stat.row_zero    = (row_q == '0);
	assign stat.blk_zero    = (blk_q == '0);
	assign stat.stream_zero = (stream_q == '0);

endmodule

@@ sv/png_stored_rgba_encoder.sv @@
// PNG encoder (RGBA8, stored deflate). First byte: IDAT sizing (scan length product,
// multiply, length sum), then 43 header beats. Each pixel byte then has a row check, block
// check, 5 block header beats at a block start, filter beat and block check at a row start,
// scan beat and stream check. The last byte adds 20 trailer beats. The sequencer walks one
// beat per cycle while the output register is free. Output register lets the next input be
// taken while a beat waits. arst_n clears control state and sets both size registers to 1.
`include "assert_macros.svh"
module png_stored_rgba_encoder #(
	parameter int MAX_DIM   = pngenc_pkg::MAX_DIM_DEF,
	parameter int BLOCK_MAX = pngenc_pkg::BLOCK_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pngenc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pngenc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // [7:0] pixel_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,  // [7:0] out_byte
	output logic                             m_tuser   // [0] last_byte
);
	import pngenc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pngenc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pngenc_dp #(
		.MAX_DIM   (MAX_DIM),
		.BLOCK_MAX (BLOCK_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	`ASSERT_STD(a_busy_after_take, s_tvalid && s_tready |=> !s_tready, "input taken while busy")
	`ASSERT_STD(a_fire_slot_free, cmd.fire |-> stat.out_free, "beat issued into full output")
	`ASSERT_STD(a_scan_in_block, cmd.fire && cmd.scan |-> !stat.blk_zero, "scan beat outside block")

endmodule
